FILE: hdl/fest_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fest_pkg
// Shared constants, codes and types of the float exclusion space table.
// ----------------------------------------------------------------------------
package fest_pkg;

    localparam int MAX_FLOATS   = 32;
    localparam int SEARCH_STEPS = 100;

    localparam int CNT_W  = $clog2(MAX_FLOATS + 1);
    localparam int ADDR_W = (MAX_FLOATS > 1) ? $clog2(MAX_FLOATS) : 1;
    localparam int STEP_W = (SEARCH_STEPS > 1) ? $clog2(SEARCH_STEPS) : 1;

    localparam logic [2:0] KIND_CLEAR   = 3'd0;
    localparam logic [2:0] KIND_ADD     = 3'd1;
    localparam logic [2:0] KIND_SPACE   = 3'd2;
    localparam logic [2:0] KIND_FIND_Y  = 3'd3;
    localparam logic [2:0] KIND_CLEAR_Y = 3'd4;

    localparam logic [1:0] CFG_LEFT_EDGE  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_EDGE = 2'd1;
    localparam logic [1:0] CFG_BASE_X     = 2'd2;
    localparam logic [1:0] CFG_BASE_Y     = 2'd3;

    localparam logic SIDE_LEFT = 1'b0;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
        logic               side;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               start;
        logic               dv;
        logic               active;
        logic [1:0]         mode;
        logic signed [31:0] y;
        logic [30:0]        height;
        logic signed [31:0] left_edge;
        logic signed [31:0] right_edge;
    } t_scan_ctl;

    typedef struct packed {
        logic signed [31:0] sl;
        logic signed [31:0] sr;
        logic               hl;
        logic               hr;
        logic signed [31:0] next;
        logic               found;
        logic signed [31:0] clr;
    } t_scan_res;

endpackage

FILE: hdl/fest_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fest_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module fest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fest_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fest_scan
// Per-entry compare unit: while dv is set, folds one stored box a cycle into
// the free span, the next float bottom above y and the clearance y.
// ----------------------------------------------------------------------------
module fest_scan (
    input  logic               i_clk,
    input  fest_pkg::t_scan_ctl i_ctl,
    input  fest_pkg::t_entry   i_entry,
    output fest_pkg::t_scan_res o_res
);

    fest_pkg::t_scan_res r_acc;
    fest_pkg::t_scan_res n_acc;

    logic signed [33:0] band_bot;
    logic               hit;
    logic               sel;

    always_comb begin
        band_bot = {{2{i_ctl.y[31]}}, i_ctl.y} + {3'b000, i_ctl.height};
        hit = i_ctl.active && (i_entry.bottom > i_ctl.y)
              && ($signed({{2{i_entry.top[31]}}, i_entry.top}) < band_bot);
        sel = (i_entry.side == fest_pkg::SIDE_LEFT) ? i_ctl.mode[0] : i_ctl.mode[1];
        n_acc = r_acc;
        if (i_ctl.start) begin
            n_acc.sl    = i_ctl.left_edge;
            n_acc.sr    = i_ctl.right_edge;
            n_acc.hl    = 1'b0;
            n_acc.hr    = 1'b0;
            n_acc.next  = '0;
            n_acc.found = 1'b0;
            n_acc.clr   = '0;
        end else if (i_ctl.dv) begin
            if (hit && i_entry.side == fest_pkg::SIDE_LEFT && i_entry.right > r_acc.sl) begin
                n_acc.sl = i_entry.right;
                n_acc.hl = 1'b1;
            end
            if (hit && i_entry.side != fest_pkg::SIDE_LEFT && i_entry.left < r_acc.sr) begin
                n_acc.sr = i_entry.left;
                n_acc.hr = 1'b1;
            end
            if (i_entry.bottom > i_ctl.y && (!r_acc.found || i_entry.bottom < r_acc.next)) begin
                n_acc.next  = i_entry.bottom;
                n_acc.found = 1'b1;
            end
            if (sel && i_entry.bottom > r_acc.clr) begin
                n_acc.clr = i_entry.bottom;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_res = r_acc;

endmodule

FILE: hdl/float_exclusion_space_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_exclusion_space_table_core
// Table of float margin boxes answering span, search and clearance requests.
// ----------------------------------------------------------------------------
// Channels: a request channel (i_in_valid / o_in_ready) with the kind and its
// operands, a result channel (o_out_valid / i_out_ready) with one result per
// request, and a register write channel (i_cfg_valid / o_cfg_ready) that is
// always ready; write registers only while no request is in flight.
// One request is worked at a time; o_in_ready is high only when idle.
// Clear and unknown kinds go straight to S_DONE; add passes S_ADD and S_LOW
// (a full table goes straight to S_DONE); span and clearance scan the stored
// boxes and then pass S_EVAL; search repeats scan and S_EVAL for up to
// SEARCH_STEPS steps. The stored boxes are read one a cycle from a single RAM
// read port into one compare unit. A finished result waits in S_DONE while
// the receiver stalls the output register, and the next request is taken
// once the result has moved into the output register.
// Reset (synchronous, active low) empties the table, clears the lowest
// bottom and the registers, and drops any result not yet taken.
// ----------------------------------------------------------------------------
module float_exclusion_space_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic               i_side,
    input  logic signed [31:0] i_box_left,
    input  logic signed [31:0] i_box_top,
    input  logic signed [31:0] i_box_right,
    input  logic signed [31:0] i_box_bottom,
    input  logic signed [31:0] i_query_y,
    input  logic [30:0]        i_query_height,
    input  logic [30:0]        i_need_width,
    input  logic [1:0]         i_clear_mode,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_space_left,
    output logic signed [31:0] o_space_right,
    output logic               o_left_intruded,
    output logic               o_right_intruded,
    output logic signed [31:0] o_result_y,
    output logic               o_store_full,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_LOW,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [31:0] space_left;
        logic signed [31:0] space_right;
        logic               has_left;
        logic               has_right;
        logic signed [31:0] result_y;
        logic               store_full;
    } t_result;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_sub = d[31:0];
        end
    endfunction

    t_state                     r_state;
    logic [fest_pkg::CNT_W-1:0] r_count;
    logic [fest_pkg::CNT_W-1:0] r_idx;
    logic [fest_pkg::STEP_W-1:0] r_step;
    logic                       r_dv;
    logic signed [31:0]         r_lb;
    logic signed [31:0]         r_left_edge;
    logic signed [31:0]         r_right_edge;
    logic signed [31:0]         r_base_x;
    logic signed [31:0]         r_base_y;
    logic                       r_out_valid;
    t_result                    r_res;
    t_result                    r_out;

    logic [2:0]                 r_kind;
    logic                       r_side;
    logic signed [31:0]         r_box_left;
    logic signed [31:0]         r_box_top;
    logic signed [31:0]         r_box_right;
    logic signed [31:0]         r_box_bottom;
    logic signed [31:0]         r_y;
    logic [30:0]                r_height;
    logic [30:0]                r_req;
    logic [1:0]                 r_mode;

    fest_pkg::t_entry           wr_entry;
    fest_pkg::t_entry           rd_entry;
    logic [fest_pkg::ENTRY_W-1:0] rd_data;
    fest_pkg::t_scan_ctl        scan_ctl;
    fest_pkg::t_scan_res        scan_res;
    t_result                    full_res;
    logic                       in_acc;
    logic                       ram_we;
    logic                       ram_re;
    logic                       active;
    logic                       fits;
    logic signed [31:0]         sr_out;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign active = (r_count != '0) && (r_y < r_lb);

    always_comb begin
        full_res            = '0;
        full_res.store_full = 1'b1;
    end

    always_comb begin
        wr_entry.left   = sat_sub(r_box_left, r_base_x);
        wr_entry.top    = sat_sub(r_box_top, r_base_y);
        wr_entry.right  = sat_sub(r_box_right, r_base_x);
        wr_entry.bottom = sat_sub(r_box_bottom, r_base_y);
        wr_entry.side   = r_side;
    end

    assign ram_we   = (r_state == S_ADD);
    assign ram_re   = (r_state == S_SCAN) && (r_idx < r_count);
    assign rd_entry = fest_pkg::t_entry'(rd_data);

    fest_ram #(
        .WIDTH (fest_pkg::ENTRY_W),
        .DEPTH (fest_pkg::MAX_FLOATS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[fest_pkg::ADDR_W-1:0]),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_idx[fest_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        scan_ctl.start      = (r_state != S_SCAN);
        scan_ctl.dv         = r_dv;
        scan_ctl.active     = active;
        scan_ctl.mode       = r_mode;
        scan_ctl.y          = r_y;
        scan_ctl.height     = r_height;
        scan_ctl.left_edge  = r_left_edge;
        scan_ctl.right_edge = r_right_edge;
    end

    fest_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_entry (rd_entry),
        .o_res   (scan_res)
    );

    logic signed [32:0] span_w;
    assign span_w = {scan_res.sr[31], scan_res.sr} - {scan_res.sl[31], scan_res.sl};

    always_comb begin
        if (span_w[32]) begin
            fits = active && (r_req == '0);
        end else begin
            fits = span_w >= $signed({2'b00, r_req});
        end
        sr_out = (active && scan_res.sr < scan_res.sl) ? scan_res.sl : scan_res.sr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_step       <= '0;
            r_dv         <= 1'b0;
            r_lb         <= '0;
            r_left_edge  <= '0;
            r_right_edge <= '0;
            r_base_x     <= '0;
            r_base_y     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fest_pkg::CFG_LEFT_EDGE:  r_left_edge  <= i_cfg_data;
                    fest_pkg::CFG_RIGHT_EDGE: r_right_edge <= i_cfg_data;
                    fest_pkg::CFG_BASE_X:     r_base_x     <= i_cfg_data;
                    fest_pkg::CFG_BASE_Y:     r_base_y     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind       <= i_kind;
                        r_side       <= i_side;
                        r_box_left   <= i_box_left;
                        r_box_top    <= i_box_top;
                        r_box_right  <= i_box_right;
                        r_box_bottom <= i_box_bottom;
                        r_y          <= i_query_y;
                        r_height     <= i_query_height;
                        r_req        <= i_need_width;
                        r_mode       <= i_clear_mode;
                        r_idx        <= '0;
                        r_dv         <= 1'b0;
                        r_step       <= '0;
                        case (i_kind)
                            fest_pkg::KIND_CLEAR: begin
                                r_res   <= '0;
                                r_count <= '0;
                                r_lb    <= '0;
                                r_state <= S_DONE;
                            end
                            fest_pkg::KIND_ADD: begin
                                if (r_count == fest_pkg::CNT_W'(fest_pkg::MAX_FLOATS)) begin
                                    r_res   <= full_res;
                                    r_state <= S_DONE;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_ADD;
                                end
                            end
                            fest_pkg::KIND_SPACE, fest_pkg::KIND_FIND_Y,
                            fest_pkg::KIND_CLEAR_Y: begin
                                r_res   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    r_y     <= wr_entry.bottom;
                    r_count <= r_count + 1'b1;
                    r_state <= S_LOW;
                end
                S_LOW: begin
                    if (r_y > r_lb) begin
                        r_lb <= r_y;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_dv <= ram_re;
                    if (ram_re) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_dv) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    case (r_kind)
                        fest_pkg::KIND_SPACE: begin
                            r_res.space_left  <= scan_res.sl;
                            r_res.space_right <= sr_out;
                            r_res.has_left    <= scan_res.hl;
                            r_res.has_right   <= scan_res.hr;
                            r_state           <= S_DONE;
                        end
                        fest_pkg::KIND_FIND_Y: begin
                            if (fits || !scan_res.found) begin
                                r_res.result_y <= r_y;
                                r_state        <= S_DONE;
                            end else begin
                                r_y <= scan_res.next;
                                if (r_step == fest_pkg::STEP_W'(fest_pkg::SEARCH_STEPS - 1)) begin
                                    r_res.result_y <= scan_res.next;
                                    r_state        <= S_DONE;
                                end else begin
                                    r_step  <= r_step + 1'b1;
                                    r_idx   <= '0;
                                    r_dv    <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                        end
                        fest_pkg::KIND_CLEAR_Y: begin
                            r_res.result_y <= scan_res.clr;
                            r_state        <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_space_left     = r_out.space_left;
    assign o_space_right    = r_out.space_right;
    assign o_left_intruded  = r_out.has_left;
    assign o_right_intruded = r_out.has_right;
    assign o_result_y       = r_out.result_y;
    assign o_store_full     = r_out.store_full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fest_pkg::CNT_W'(fest_pkg::MAX_FLOATS))
        else $error("box count beyond table depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("request accepted without starting work");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past stored boxes");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < fest_pkg::STEP_W'(fest_pkg::SEARCH_STEPS))
        else $error("search step count overrun");
`endif

endmodule

FILE: sim/fest_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fest_tb_pkg
// Request and result types and the scoreboard of the float table bench. The
// scoreboard keeps its own copy of the box table and the registers, works
// out the answer of every accepted request and checks the results in order.
// ----------------------------------------------------------------------------
package fest_tb_pkg;

    import fest_pkg::*;

    localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] KIND_LAST_CODE    = 3'd7;

    localparam logic SIDE_RIGHT = 1'b1;

    localparam logic [1:0] CLR_NONE  = 2'd0;
    localparam logic [1:0] CLR_LEFT  = 2'd1;
    localparam logic [1:0] CLR_RIGHT = 2'd2;
    localparam logic [1:0] CLR_BOTH  = 2'd3;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic [30:0]        LEN_MAX   = '1;

    typedef struct packed {
        logic [2:0]         kind;
        logic               side;
        logic signed [31:0] box_left;
        logic signed [31:0] box_top;
        logic signed [31:0] box_right;
        logic signed [31:0] box_bottom;
        logic signed [31:0] query_y;
        logic [30:0]        query_height;
        logic [30:0]        need_width;
        logic [1:0]         clear_mode;
    } float_request_t;

    typedef struct packed {
        logic signed [31:0] space_left;
        logic signed [31:0] space_right;
        logic               has_left;
        logic               has_right;
        logic signed [31:0] result_y;
        logic               store_full;
    } float_answer_t;

    class float_table_scoreboard;

        logic signed [31:0] left_edge;
        logic signed [31:0] right_edge;
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        t_entry             boxes [MAX_FLOATS];
        int unsigned        left_cnt;
        int unsigned        right_cnt;
        logic signed [31:0] low_mark;
        float_answer_t      pending_answers [$];
        int unsigned        fails;

        function new();
            left_edge  = '0;
            right_edge = '0;
            base_x     = '0;
            base_y     = '0;
            left_cnt   = 0;
            right_cnt  = 0;
            low_mark   = '0;
            fails      = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                CFG_LEFT_EDGE:  left_edge  = data;
                CFG_RIGHT_EDGE: right_edge = data;
                CFG_BASE_X:     base_x     = data;
                CFG_BASE_Y:     base_y     = data;
                default: ;
            endcase
        endfunction

        function int unsigned stored();
            int unsigned n;
            n = left_cnt + right_cnt;
            return (n > MAX_FLOATS) ? MAX_FLOATS : n;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > longint'(COORD_MAX)) return COORD_MAX;
            if (v < longint'(COORD_MIN)) return COORD_MIN;
            return v[31:0];
        endfunction

        function void span_at(longint top, longint height, output longint sl,
                              output longint sr, output logic hl, output logic hr);
            longint      band_bot;
            int unsigned n;
            int          i;
            band_bot = top + height;
            n        = stored();
            sl       = left_edge;
            sr       = right_edge;
            hl       = 1'b0;
            hr       = 1'b0;
            if (n == 0 || top >= longint'(low_mark)) return;
            for (i = 0; i < n; i++) begin
                if ($signed(boxes[i].bottom) <= top || $signed(boxes[i].top) >= band_bot)
                    continue;
                if (boxes[i].side == SIDE_LEFT) begin
                    if ($signed(boxes[i].right) > sl) begin
                        sl = $signed(boxes[i].right);
                        hl = 1'b1;
                    end
                end else begin
                    if ($signed(boxes[i].left) < sr) begin
                        sr = $signed(boxes[i].left);
                        hr = 1'b1;
                    end
                end
            end
            if (sr < sl) sr = sl;
        endfunction

        function longint find_y(longint req, longint min_y, longint height);
            longint      y;
            longint      sl;
            longint      sr;
            longint      next_b;
            longint      b;
            logic        hl;
            logic        hr;
            logic        found;
            int unsigned n;
            int          step;
            int          i;
            y = min_y;
            n = stored();
            if (n == 0) return min_y;
            for (step = 0; step < SEARCH_STEPS; step++) begin
                span_at(y, height, sl, sr, hl, hr);
                if (sr - sl >= req) return y;
                found  = 1'b0;
                next_b = 0;
                for (i = 0; i < n; i++) begin
                    b = $signed(boxes[i].bottom);
                    if (b > y && (!found || b < next_b)) begin
                        next_b = b;
                        found  = 1'b1;
                    end
                end
                if (!found) break;
                y = next_b;
            end
            return y;
        endfunction

        function float_answer_t predict_answer(float_request_t rq);
            float_answer_t a;
            int unsigned   n;
            int            i;
            longint        sl;
            longint        sr;
            longint        y;
            logic          hl;
            logic          hr;
            logic          sel;
            a = '0;
            n = stored();
            case (rq.kind)
                KIND_CLEAR: begin
                    left_cnt  = 0;
                    right_cnt = 0;
                    low_mark  = '0;
                end
                KIND_ADD: begin
                    if (n >= MAX_FLOATS) begin
                        a.store_full = 1'b1;
                    end else begin
                        boxes[n].left   = clamp32(longint'(rq.box_left) - longint'(base_x));
                        boxes[n].top    = clamp32(longint'(rq.box_top) - longint'(base_y));
                        boxes[n].right  = clamp32(longint'(rq.box_right) - longint'(base_x));
                        boxes[n].bottom = clamp32(longint'(rq.box_bottom) - longint'(base_y));
                        boxes[n].side   = rq.side;
                        if (rq.side == SIDE_LEFT) left_cnt++;
                        else right_cnt++;
                        if ($signed(boxes[n].bottom) > low_mark)
                            low_mark = boxes[n].bottom;
                    end
                end
                KIND_SPACE: begin
                    span_at(rq.query_y, longint'(rq.query_height), sl, sr, hl, hr);
                    a.space_left  = sl[31:0];
                    a.space_right = sr[31:0];
                    a.has_left    = hl;
                    a.has_right   = hr;
                end
                KIND_FIND_Y: begin
                    y = find_y(longint'(rq.need_width), rq.query_y,
                               longint'(rq.query_height));
                    a.result_y = y[31:0];
                end
                KIND_CLEAR_Y: begin
                    y = 0;
                    for (i = 0; i < n; i++) begin
                        sel = (boxes[i].side == SIDE_LEFT) ? ((rq.clear_mode & CLR_LEFT) != 0)
                                                           : ((rq.clear_mode & CLR_RIGHT) != 0);
                        if (sel && $signed(boxes[i].bottom) > y) y = $signed(boxes[i].bottom);
                    end
                    a.result_y = y[31:0];
                end
                default: ;
            endcase
            return a;
        endfunction

        function void note_request(float_request_t rq);
            pending_answers.push_back(predict_answer(rq));
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_answer(float_answer_t got);
            float_answer_t want;
            if (pending_answers.size() == 0) begin
                $error("result with no request outstanding");
                fails++;
                return;
            end
            want = pending_answers.pop_front();
            compare_field("space_left", want.space_left, got.space_left);
            compare_field("space_right", want.space_right, got.space_right);
            compare_field("left_intruded", want.has_left, got.has_left);
            compare_field("right_intruded", want.has_right, got.has_right);
            compare_field("result_y", want.result_y, got.result_y);
            compare_field("store_full", want.store_full, got.store_full);
        endfunction

    endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench of the float exclusion space table. A short directed pass covers the
// empty table, band edges, raised spans, the search, every clearance mode,
// unknown kinds and saturating adds; then four random phases fill and query
// the table under changing registers and handshake pressure, including a
// full table. Every result is checked against the scoreboard in order.
// ----------------------------------------------------------------------------
module tb_top;

    import fest_pkg::*;
    import fest_tb_pkg::*;

    // run limit covers the worst search per request, plus stalls, with margin
    localparam longint RUN_LIMIT = 25_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_kind;
    logic               i_side;
    logic signed [31:0] i_box_left;
    logic signed [31:0] i_box_top;
    logic signed [31:0] i_box_right;
    logic signed [31:0] i_box_bottom;
    logic signed [31:0] i_query_y;
    logic [30:0]        i_query_height;
    logic [30:0]        i_need_width;
    logic [1:0]         i_clear_mode;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_space_left;
    logic signed [31:0] o_space_right;
    logic               o_left_intruded;
    logic               o_right_intruded;
    logic signed [31:0] o_result_y;
    logic               o_store_full;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    float_table_scoreboard sb;
    int unsigned           sender_idle_pct    = 0;
    int unsigned           receiver_stall_pct = 0;
    int unsigned           requests_sent      = 0;
    longint                cycles             = 0;

    float_exclusion_space_table_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_side           (i_side),
        .i_box_left       (i_box_left),
        .i_box_top        (i_box_top),
        .i_box_right      (i_box_right),
        .i_box_bottom     (i_box_bottom),
        .i_query_y        (i_query_y),
        .i_query_height   (i_query_height),
        .i_need_width     (i_need_width),
        .i_clear_mode     (i_clear_mode),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_space_left     (o_space_left),
        .o_space_right    (o_space_right),
        .o_left_intruded  (o_left_intruded),
        .o_right_intruded (o_right_intruded),
        .o_result_y       (o_result_y),
        .o_store_full     (o_store_full),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        float_answer_t got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.space_left  = o_space_left;
            got.space_right = o_space_right;
            got.has_left    = o_left_intruded;
            got.has_right   = o_right_intruded;
            got.result_y    = o_result_y;
            got.store_full  = o_store_full;
            sb.check_answer(got);
        end
    end

    function automatic logic signed [31:0] px(int n);
        return n * 256;
    endfunction

    // snap to a 16 px grid so that edges often coincide
    function automatic logic signed [31:0] layout_coord(int lo_px, int hi_px);
        int v;
        v = lo_px + 16 * int'($urandom_range(0, (hi_px - lo_px) / 16));
        if ($urandom_range(3) == 0) return v * 256 + int'($urandom_range(0, 255));
        return v * 256;
    endfunction

    function automatic float_request_t noise_request();
        float_request_t rq;
        rq.kind         = 3'($urandom);
        rq.side         = 1'($urandom);
        rq.box_left     = $urandom;
        rq.box_top      = $urandom;
        rq.box_right    = $urandom;
        rq.box_bottom   = $urandom;
        rq.query_y      = $urandom;
        rq.query_height = 31'($urandom);
        rq.need_width   = 31'($urandom);
        rq.clear_mode   = 2'($urandom);
        return rq;
    endfunction

    task automatic send_request(input float_request_t rq);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind         = rq.kind;
        i_side         = rq.side;
        i_box_left     = rq.box_left;
        i_box_top      = rq.box_top;
        i_box_right    = rq.box_right;
        i_box_bottom   = rq.box_bottom;
        i_query_y      = rq.query_y;
        i_query_height = rq.query_height;
        i_need_width   = rq.need_width;
        i_clear_mode   = rq.clear_mode;
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(rq);
        if (rq.kind <= KIND_CLEAR_Y) requests_sent++;
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_kind(input logic [2:0] kind);
        float_request_t rq;
        rq      = noise_request();
        rq.kind = kind;
        send_request(rq);
    endtask

    task automatic add_box(input logic side, input logic signed [31:0] l,
                           input logic signed [31:0] t, input logic signed [31:0] r,
                           input logic signed [31:0] b);
        float_request_t rq;
        rq            = noise_request();
        rq.kind       = KIND_ADD;
        rq.side       = side;
        rq.box_left   = l;
        rq.box_top    = t;
        rq.box_right  = r;
        rq.box_bottom = b;
        send_request(rq);
    endtask

    task automatic space_query(input logic signed [31:0] y, input logic [30:0] h);
        float_request_t rq;
        rq              = noise_request();
        rq.kind         = KIND_SPACE;
        rq.query_y      = y;
        rq.query_height = h;
        send_request(rq);
    endtask

    task automatic find_y_query(input logic signed [31:0] y, input logic [30:0] h,
                                input logic [30:0] w);
        float_request_t rq;
        rq              = noise_request();
        rq.kind         = KIND_FIND_Y;
        rq.query_y      = y;
        rq.query_height = h;
        rq.need_width   = w;
        send_request(rq);
    endtask

    task automatic clearance_query(input logic [1:0] mode);
        float_request_t rq;
        rq            = noise_request();
        rq.kind       = KIND_CLEAR_Y;
        rq.clear_mode = mode;
        send_request(rq);
    endtask

    task automatic add_float();
        logic signed [31:0] l;
        logic signed [31:0] t;
        l = layout_coord(-16, 640);
        t = layout_coord(-32, 800);
        if ($urandom_range(19) == 0) begin
            add_box(1'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
            add_box(1'($urandom), l + sb.base_x, t + sb.base_y,
                    l + layout_coord(0, 320) + sb.base_x,
                    t + layout_coord(0, 240) + sb.base_y);
        end
    endtask

    task automatic query_table();
        logic signed [31:0] y;
        logic [30:0]        h;
        y = layout_coord(-64, 1100);
        h = ($urandom_range(3) == 0) ? '0 : 31'(layout_coord(0, 240));
        if ($urandom_range(9) == 0) begin
            y = $urandom;
            h = 31'($urandom);
        end
        case ($urandom_range(2))
            0: space_query(y, h);
            1: find_y_query(y, h, ($urandom_range(9) == 0) ? 31'($urandom)
                                                           : 31'(layout_coord(0, 900)));
            default: clearance_query(2'($urandom_range(3)));
        endcase
    endtask

    task automatic run_sequence();
        int adds;
        adds = ($urandom_range(7) == 0) ? int'($urandom_range(28, 40))
                                        : int'($urandom_range(0, 10));
        if ($urandom_range(9) != 0) send_kind(KIND_CLEAR);
        repeat (adds) begin
            if ($urandom_range(11) == 0) send_request(noise_request());
            else add_float();
            if ($urandom_range(3) == 0) query_table();
        end
        repeat ($urandom_range(2, 8)) query_table();
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                             input logic signed [31:0] le, input logic signed [31:0] re,
                             input logic signed [31:0] ox, input logic signed [31:0] oy,
                             input int unsigned target);
        int unsigned goal;
        drain();
        write_reg(CFG_LEFT_EDGE, le);
        write_reg(CFG_RIGHT_EDGE, re);
        write_reg(CFG_BASE_X, ox);
        write_reg(CFG_BASE_Y, oy);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        goal               = requests_sent + target;
        while (requests_sent < goal) run_sequence();
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_CLEAR;
        i_side         = SIDE_LEFT;
        i_box_left     = '0;
        i_box_top      = '0;
        i_box_right    = '0;
        i_box_bottom   = '0;
        i_query_y      = '0;
        i_query_height = '0;
        i_need_width   = '0;
        i_clear_mode   = CLR_NONE;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_LEFT_EDGE;
        i_cfg_data     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_LEFT_EDGE, '0);
        write_reg(CFG_RIGHT_EDGE, px(800));
        write_reg(CFG_BASE_X, '0);
        write_reg(CFG_BASE_Y, '0);
        send_kind(KIND_FIRST_UNUSED);
        send_kind(KIND_FIRST_UNUSED + 3'd1);
        send_kind(KIND_LAST_CODE);
        space_query(COORD_MIN, LEN_MAX);
        find_y_query(COORD_MAX, '0, '0);
        clearance_query(CLR_BOTH);
        add_box(SIDE_LEFT, '0, '0, px(100), px(100));
        add_box(SIDE_RIGHT, px(600), px(50), px(800), px(150));
        add_box(SIDE_LEFT, '0, px(40), px(700), px(90));
        space_query('0, 31'(px(10)));
        // left float reaches past the right one: right bound is raised
        space_query(px(60), 31'(px(10)));
        space_query(px(100), '0);
        space_query(px(150), 31'(px(10)));
        find_y_query('0, 31'(px(10)), 31'(px(700)));
        find_y_query('0, 31'(px(10)), LEN_MAX);
        clearance_query(CLR_NONE);
        clearance_query(CLR_LEFT);
        clearance_query(CLR_RIGHT);
        clearance_query(CLR_BOTH);
        send_kind(KIND_CLEAR);
        drain();
        // origins at the extremes drive the box left and top into saturation
        write_reg(CFG_BASE_X, COORD_MAX);
        write_reg(CFG_BASE_Y, COORD_MIN);
        add_box(SIDE_RIGHT, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        clearance_query(CLR_BOTH);
        space_query(COORD_MIN, LEN_MAX);

        run_phase(0, 0, '0, px(800), '0, '0, 475);
        run_phase(73, 0, COORD_MIN, COORD_MAX, px(-24), px(12), 475);
        run_phase(0, 73, $urandom, $urandom, px(30), px(-30), 475);
        run_phase(20, 20, px(16), px(600), px(-40), px(25), 475);
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/fest_pkg.sv
hdl/fest_ram.sv
hdl/fest_scan.sv
hdl/float_exclusion_space_table_core.sv
sim/fest_tb_pkg.sv
sim/tb_top.sv
